// ===== src/bba_pkg.sv =====
// Shared types and codes for the buddy block allocator.
// Holds the order width, the sequencer state type, node kind, status and operation codes.
// No dependencies.
package bba_pkg;

    // Width of a stored block order; orders never exceed fifteen.
    localparam int unsigned ORD_W = 4;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_USED = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [17:0] {
        S_CLEAR  = 18'b000000000000000001,
        S_IDLE   = 18'b000000000000000010,
        S_FIT    = 18'b000000000000000100,
        S_SEARCH = 18'b000000000000001000,
        S_URD    = 18'b000000000000010000,
        S_UWRA   = 18'b000000000000100000,
        S_UWRB   = 18'b000000000001000000,
        S_SPLIT  = 18'b000000000010000000,
        S_PUSHA  = 18'b000000000100000000,
        S_PUSHB  = 18'b000000001000000000,
        S_MARK   = 18'b000000010000000000,
        S_FCHK   = 18'b000000100000000000,
        S_FRD    = 18'b000001000000000000,
        S_FKIND  = 18'b000010000000000000,
        S_MSTEP  = 18'b000100000000000000,
        S_MRD    = 18'b001000000000000000,
        S_MCHK   = 18'b010000000000000000,
        S_FINISH = 18'b100000000000000000
    } state_t;

endpackage

// ===== src/bba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for every node store of the allocator. No dependencies.
module bba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/buddy_block_allocator_unit.sv =====
// Buddy block allocator: top level with sequencer, free-list heads and node stores.
// Depends on bba_pkg and bba_ram.
// After reset a clearing pass writes all 2^(NUM_LEVELS-1) entries of the node stores and
// no transaction is accepted during it. One request is handled at a time; the sequencer
// steps one order at a time while fitting, searching, splitting and merging. A free with a
// misaligned or out-of-range address, or of a block not in use, is rejected as a bad free.
// The input is ready again in the cycle the result appears, unless the last one waits.
module buddy_block_allocator_unit #(
    parameter int unsigned NUM_LEVELS     = 8,
    parameter int unsigned MIN_ORDER_LOG2 = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [19:0] s_request_size,
    input  logic [31:0] s_block_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_result_address,
    output logic [4:0]  m_block_log2
);

    localparam int unsigned OW       = bba_pkg::ORD_W;
    localparam int unsigned IW       = NUM_LEVELS - 1;
    localparam int unsigned LW       = NUM_LEVELS;
    localparam int unsigned LVW      = $clog2(NUM_LEVELS);
    localparam int unsigned NODES    = 1 << IW;
    localparam int unsigned TOP_LOG2 = MIN_ORDER_LOG2 + NUM_LEVELS - 1;
    localparam logic [OW-1:0] TOP    = OW'(NUM_LEVELS - 1);
    localparam logic [LW-1:0] NIL    = LW'(1) << IW;

    bba_pkg::state_t state_reg, state_next;

    logic [31:0]   heap_base_reg;
    logic [IW-1:0] clr_reg, clr_next;
    logic          op_reg, op_next;
    logic [19:0]   size_reg, size_next;
    logic [31:0]   addr_reg, addr_next;
    logic [OW-1:0] want_reg, want_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [IW-1:0] node_reg, node_next;
    logic [IW-1:0] ulk_reg, ulk_next;
    logic [IW-1:0] push_reg, push_next;
    logic [LW-1:0] hold_reg, hold_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [4:0]    res_log2_reg, res_log2_next;
    logic [LW-1:0] head_reg [NUM_LEVELS];
    logic [LW-1:0] head_next [NUM_LEVELS];
    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [31:0]   m_addr_reg, m_addr_next;
    logic [4:0]    m_log2_reg, m_log2_next;

    // Node store ports.
    logic          kind_we, level_we, next_we, prev_we;
    logic [IW-1:0] kind_wa, level_wa, next_wa, prev_wa;
    logic [1:0]    kind_wd, kind_rd;
    logic [OW-1:0] level_wd, level_rd;
    logic [LW-1:0] next_wd, next_rd, prev_wd, prev_rd;
    logic [IW-1:0] raddr;

    // Shared order unit: size fit test, head lookup, buddy index and offset checks.
    logic [4:0]     fit_log2;
    logic           too_big;
    logic [LW-1:0]  head_sel;
    logic [OW-1:0]  ord_dec;
    logic [IW-1:0]  buddy;
    logic [31:0]    offset;
    logic           off_bad;
    logic [IW-1:0]  ulk_min;

    assign fit_log2 = 5'(MIN_ORDER_LOG2) + {1'b0, want_reg};
    assign too_big  = (fit_log2 < 5'd20) && ({1'b0, size_reg} > (21'd1 << fit_log2));
    assign head_sel = head_reg[ord_reg[LVW-1:0]];
    assign ord_dec  = (state_reg == bba_pkg::S_SPLIT) ? (ord_reg - OW'(1)) : ord_reg;
    assign buddy    = node_reg ^ (IW'(1) << ord_dec);
    assign offset   = addr_reg - heap_base_reg;
    assign off_bad  = (offset[MIN_ORDER_LOG2-1:0] != '0) || ((offset >> TOP_LOG2) != 32'd0);
    assign ulk_min  = (ulk_reg < node_reg) ? ulk_reg : node_reg;
    assign raddr    = (state_reg == bba_pkg::S_FRD) ? node_reg : ulk_reg;

    bba_ram #(.WIDTH(2), .DEPTH(NODES)) u_kind_ram (
        .aclk(aclk), .we(kind_we), .waddr(kind_wa), .wdata(kind_wd),
        .raddr(raddr), .rdata(kind_rd)
    );
    bba_ram #(.WIDTH(OW), .DEPTH(NODES)) u_level_ram (
        .aclk(aclk), .we(level_we), .waddr(level_wa), .wdata(level_wd),
        .raddr(raddr), .rdata(level_rd)
    );
    bba_ram #(.WIDTH(LW), .DEPTH(NODES)) u_next_ram (
        .aclk(aclk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(raddr), .rdata(next_rd)
    );
    bba_ram #(.WIDTH(LW), .DEPTH(NODES)) u_prev_ram (
        .aclk(aclk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(raddr), .rdata(prev_rd)
    );

    // Sequencer: next state, working registers and node store writes.
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        want_next       = want_reg;
        ord_next        = ord_reg;
        node_next       = node_reg;
        ulk_next        = ulk_reg;
        push_next       = push_reg;
        hold_next       = hold_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_log2_next   = res_log2_reg;
        head_next       = head_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_log2_next     = m_log2_reg;
        kind_we  = 1'b0; kind_wa  = ulk_reg; kind_wd  = bba_pkg::KIND_NONE;
        level_we = 1'b0; level_wa = ulk_reg; level_wd = ord_reg;
        next_we  = 1'b0; next_wa  = ulk_reg; next_wd  = NIL;
        prev_we  = 1'b0; prev_wa  = ulk_reg; prev_wd  = NIL;

        case (state_reg)
            bba_pkg::S_CLEAR: begin
                kind_we  = 1'b1; kind_wa  = clr_reg;
                level_we = 1'b1; level_wa = clr_reg;
                next_we  = 1'b1; next_wa  = clr_reg;
                prev_we  = 1'b1; prev_wa  = clr_reg;
                kind_wd  = (clr_reg == '0) ? bba_pkg::KIND_FREE : bba_pkg::KIND_NONE;
                level_wd = (clr_reg == '0) ? TOP : '0;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(NODES - 1)) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_operation;
                    size_next = s_request_size;
                    addr_next = s_block_address;
                    want_next = '0;
                    state_next = (s_operation == bba_pkg::OP_ALLOC) ?
                                 bba_pkg::S_FIT : bba_pkg::S_FCHK;
                end
            end
            // Find the smallest order that holds the request.
            bba_pkg::S_FIT: begin
                if (want_reg < TOP && too_big) begin
                    want_next = want_reg + OW'(1);
                end else if (too_big) begin
                    res_status_next = bba_pkg::ST_NO_SPACE;
                    res_addr_next   = '0;
                    res_log2_next   = '0;
                    state_next      = bba_pkg::S_FINISH;
                end else begin
                    ord_next   = want_reg;
                    state_next = bba_pkg::S_SEARCH;
                end
            end
            // Walk up to the first non-empty free list.
            bba_pkg::S_SEARCH: begin
                if (ord_reg < TOP && head_sel[IW]) begin
                    ord_next = ord_reg + OW'(1);
                end else if (head_sel[IW]) begin
                    res_status_next = bba_pkg::ST_NO_SPACE;
                    res_addr_next   = '0;
                    res_log2_next   = '0;
                    state_next      = bba_pkg::S_FINISH;
                end else begin
                    node_next  = head_sel[IW-1:0];
                    ulk_next   = head_sel[IW-1:0];
                    state_next = bba_pkg::S_URD;
                end
            end
            bba_pkg::S_URD: begin
                state_next = bba_pkg::S_UWRA;
            end
            // Unlink: repair the neighbours of the node being removed.
            bba_pkg::S_UWRA: begin
                if (!prev_rd[IW]) begin
                    next_we = 1'b1;
                    next_wa = prev_rd[IW-1:0];
                    next_wd = next_rd;
                end else begin
                    head_next[ord_reg[LVW-1:0]] = next_rd;
                end
                if (!next_rd[IW]) begin
                    prev_we = 1'b1;
                    prev_wa = next_rd[IW-1:0];
                    prev_wd = prev_rd;
                end
                state_next = bba_pkg::S_UWRB;
            end
            // Unlink: clear the removed node's links; a merge also moves up one order.
            bba_pkg::S_UWRB: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                if (op_reg == bba_pkg::OP_FREE) begin
                    kind_we    = 1'b1;
                    node_next  = ulk_min;
                    ord_next   = ord_reg + OW'(1);
                    state_next = bba_pkg::S_MSTEP;
                end else begin
                    state_next = bba_pkg::S_SPLIT;
                end
            end
            // Split downward, pushing each upper buddy on its list.
            bba_pkg::S_SPLIT: begin
                if (ord_reg > want_reg) begin
                    ord_next   = ord_dec;
                    push_next  = buddy;
                    state_next = bba_pkg::S_PUSHA;
                end else begin
                    state_next = bba_pkg::S_MARK;
                end
            end
            bba_pkg::S_PUSHA: begin
                kind_we  = 1'b1; kind_wa  = push_reg; kind_wd = bba_pkg::KIND_FREE;
                level_we = 1'b1; level_wa = push_reg;
                next_we  = 1'b1; next_wa  = push_reg; next_wd = head_sel;
                prev_we  = 1'b1; prev_wa  = push_reg;
                hold_next = head_sel;
                head_next[ord_reg[LVW-1:0]] = {1'b0, push_reg};
                state_next = bba_pkg::S_PUSHB;
            end
            bba_pkg::S_PUSHB: begin
                if (!hold_reg[IW]) begin
                    prev_we = 1'b1;
                    prev_wa = hold_reg[IW-1:0];
                    prev_wd = {1'b0, push_reg};
                end
                if (op_reg == bba_pkg::OP_FREE) begin
                    res_status_next = bba_pkg::ST_DONE;
                    res_addr_next   = heap_base_reg + (32'(push_reg) << MIN_ORDER_LOG2);
                    res_log2_next   = 5'(MIN_ORDER_LOG2) + {1'b0, ord_reg};
                    state_next      = bba_pkg::S_FINISH;
                end else begin
                    state_next = bba_pkg::S_SPLIT;
                end
            end
            bba_pkg::S_MARK: begin
                kind_we  = 1'b1; kind_wa  = node_reg; kind_wd  = bba_pkg::KIND_USED;
                level_we = 1'b1; level_wa = node_reg; level_wd = want_reg;
                res_status_next = bba_pkg::ST_DONE;
                res_addr_next   = heap_base_reg + (32'(node_reg) << MIN_ORDER_LOG2);
                res_log2_next   = 5'(MIN_ORDER_LOG2) + {1'b0, want_reg};
                state_next      = bba_pkg::S_FINISH;
            end
            // Free: range and alignment check of the offset.
            bba_pkg::S_FCHK: begin
                if (off_bad) begin
                    res_status_next = bba_pkg::ST_BAD_FREE;
                    res_addr_next   = '0;
                    res_log2_next   = '0;
                    state_next      = bba_pkg::S_FINISH;
                end else begin
                    node_next  = offset[TOP_LOG2-1:MIN_ORDER_LOG2];
                    state_next = bba_pkg::S_FRD;
                end
            end
            bba_pkg::S_FRD: begin
                state_next = bba_pkg::S_FKIND;
            end
            bba_pkg::S_FKIND: begin
                if (kind_rd != bba_pkg::KIND_USED) begin
                    res_status_next = bba_pkg::ST_BAD_FREE;
                    res_addr_next   = '0;
                    res_log2_next   = '0;
                    state_next      = bba_pkg::S_FINISH;
                end else begin
                    kind_we    = 1'b1;
                    kind_wa    = node_reg;
                    ord_next   = (level_rd > TOP) ? TOP : level_rd;
                    state_next = bba_pkg::S_MSTEP;
                end
            end
            // Merge loop: look at the buddy of equal order.
            bba_pkg::S_MSTEP: begin
                if (ord_reg < TOP) begin
                    ulk_next   = buddy;
                    state_next = bba_pkg::S_MRD;
                end else begin
                    push_next  = node_reg;
                    state_next = bba_pkg::S_PUSHA;
                end
            end
            bba_pkg::S_MRD: begin
                state_next = bba_pkg::S_MCHK;
            end
            bba_pkg::S_MCHK: begin
                if (kind_rd != bba_pkg::KIND_FREE || level_rd != ord_reg) begin
                    push_next  = node_reg;
                    state_next = bba_pkg::S_PUSHA;
                end else begin
                    state_next = bba_pkg::S_UWRA;
                end
            end
            // Hand the result to the output register once it is free.
            bba_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_log2_next   = res_log2_reg;
                    state_next    = bba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers with reset, payload registers without.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bba_pkg::S_CLEAR;
            clr_reg       <= '0;
            heap_base_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= (i == NUM_LEVELS - 1) ? '0 : NIL;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            if (cfg_wr_en) begin
                heap_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        want_reg       <= want_next;
        ord_reg        <= ord_next;
        node_reg       <= node_next;
        ulk_reg        <= ulk_next;
        push_reg       <= push_next;
        hold_reg       <= hold_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_log2_reg   <= res_log2_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_log2_reg     <= m_log2_next;
    end

    assign s_ready          = (state_reg == bba_pkg::S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_address = m_addr_reg;
    assign m_block_log2     = m_log2_reg;

endmodule
